>>> rtl/rsf_pkg.sv
// Package for the rotating shadow framebuffer: geometry constants, beat types
// and the command record that the front end hands to the back end.
// Depends on nothing; every other file but rsf_ram imports it.
`timescale 1ns / 1ps
`default_nettype none

package rsf_pkg;

  // Landscape frame geometry and chunk height of the panel link.
  localparam int UI_WIDTH   = 640;
  localparam int UI_HEIGHT  = 172;
  localparam int CHUNK_ROWS = 64;

  // Field widths fixed by the beat formats.
  localparam int X_W  = 10;
  localparam int Y_W  = 8;
  localparam int PX_W = 16;

  // Store size and counter widths that follow from the geometry.
  localparam int DEPTH  = UI_WIDTH * UI_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int ROW_W  = $clog2(UI_WIDTH);
  localparam int COL_W  = (UI_HEIGHT > 1) ? $clog2(UI_HEIGHT) : 1;
  localparam int CK_W   = (CHUNK_ROWS > 1) ? $clog2(CHUNK_ROWS) : 1;

  // Queue between front and back end, and the result queue.
  localparam int CQ_DEPTH = 4;
  localparam int CQ_AW    = $clog2(CQ_DEPTH);
  localparam int CQ_CW    = $clog2(CQ_DEPTH + 1);
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);
  localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

  // Command codes of an input beat.
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  typedef struct packed {
    logic            command;
    logic [X_W-1:0]  ui_x;
    logic [Y_W-1:0]  ui_y;
    logic [PX_W-1:0] pixel;
  } in_item_t;

  typedef struct packed {
    logic [PX_W-1:0] out_pixel;
    logic [X_W-1:0]  native_row;
    logic [Y_W-1:0]  native_col;
    logic            chunk_last;
    logic            frame_last;
  } out_item_t;

  // One classified operation for the back end.
  typedef struct packed {
    logic              is_read;
    logic [ADDR_W-1:0] addr;
    logic [PX_W-1:0]   wdata;
    logic [X_W-1:0]    row;
    logic [Y_W-1:0]    col;
    logic              chunk_last;
    logic              frame_last;
  } cmd_t;

  // Status of the command queue as seen by its neighbors.
  typedef struct packed {
    logic full;
    logic empty;
  } cq_status_t;

endpackage

`default_nettype wire

>>> rtl/rsf_ram.sv
// Generic single-port RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module rsf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic             we,
  input  wire logic [AW-1:0]    addr,
  input  wire logic [WIDTH-1:0] wdata,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, or read into the output register.
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/rsf_front.sv
// Front end: accepts input beats, drops out-of-range writes, maps writes to
// store addresses and tags reads from the raster counter. Uses rsf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rsf_front import rsf_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_push,
  input  wire in_item_t   in_data,
  input  wire cq_status_t cq_status,
  output logic            cq_push,
  output cmd_t            cq_cmd
);

  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [CK_W-1:0]   ck_r, ck_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;

  logic              accept;
  logic              is_read;
  logic              in_range;
  logic              row_end;
  logic              frame_end;
  logic              chunk_end;
  logic [ADDR_W-1:0] wrow;
  logic [ADDR_W-1:0] waddr;

  assign accept  = in_push && !cq_status.full;
  assign is_read = (in_data.command == CMD_READ);

  // Write mapping: landscape column x becomes native row UI_WIDTH-1-x.
  assign in_range = (32'(in_data.ui_x) < 32'(UI_WIDTH)) &&
                    (32'(in_data.ui_y) < 32'(UI_HEIGHT));
  assign wrow  = ADDR_W'(UI_WIDTH - 1) - ADDR_W'(in_data.ui_x);
  assign waddr = ADDR_W'(wrow * ADDR_W'(UI_HEIGHT)) + ADDR_W'(in_data.ui_y);

  // Raster position flags of the next read.
  assign row_end   = (col_r == COL_W'(UI_HEIGHT - 1));
  assign frame_end = (idx_r == ADDR_W'(DEPTH - 1));
  assign chunk_end = row_end && ((ck_r == CK_W'(CHUNK_ROWS - 1)) || frame_end);

  // Build the command; the store holds the byte-swapped pixel.
  always_comb begin
    cq_push           = accept && (is_read || in_range);
    cq_cmd.is_read    = is_read;
    cq_cmd.addr       = is_read ? idx_r : waddr;
    cq_cmd.wdata      = {in_data.pixel[7:0], in_data.pixel[15:8]};
    cq_cmd.row        = X_W'(row_r);
    cq_cmd.col        = Y_W'(col_r);
    cq_cmd.chunk_last = chunk_end;
    cq_cmd.frame_last = frame_end;
  end

  // Advance the raster counter on every accepted read.
  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    ck_nxt  = ck_r;
    idx_nxt = idx_r;
    if (accept && is_read) begin
      if (frame_end) begin
        row_nxt = '0;
        col_nxt = '0;
        ck_nxt  = '0;
        idx_nxt = '0;
      end else begin
        idx_nxt = idx_r + ADDR_W'(1);
        if (row_end) begin
          col_nxt = '0;
          row_nxt = row_r + ROW_W'(1);
          ck_nxt  = (ck_r == CK_W'(CHUNK_ROWS - 1)) ? '0 : ck_r + CK_W'(1);
        end else begin
          col_nxt = col_r + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
      ck_r  <= '0;
      idx_r <= '0;
    end else begin
      row_r <= row_nxt;
      col_r <= col_nxt;
      ck_r  <= ck_nxt;
      idx_r <= idx_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/rsf_cmdq.sv
// Short command queue between the front end and the back end.
// Uses rsf_pkg for the command record and the queue depth.
`timescale 1ns / 1ps
`default_nettype none

module rsf_cmdq import rsf_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  input  wire logic pop,
  output cq_status_t status,
  output cmd_t      head
);

  cmd_t             slot_r [CQ_DEPTH];
  logic [CQ_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CQ_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CQ_CW-1:0] cnt_r, cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign status.full  = (cnt_r == CQ_CW'(CQ_DEPTH));
  assign status.empty = (cnt_r == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = slot_r[rd_ptr_r];

  // Pointer and fill-count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == CQ_AW'(CQ_DEPTH - 1)) ? '0 : wr_ptr_r + CQ_AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == CQ_AW'(CQ_DEPTH - 1)) ? '0 : rd_ptr_r + CQ_AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CQ_CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CQ_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Payload slots need no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

>>> rtl/rsf_back.sv
// Back end: carries out queued writes and reads on the shadow store and
// queues read results for the output side. Uses rsf_pkg and rsf_ram.
`timescale 1ns / 1ps
`default_nettype none

module rsf_back import rsf_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cq_status_t cq_status,
  input  wire cmd_t       cq_head,
  output logic            cq_pop,
  input  wire logic       out_pop,
  output logic            out_empty,
  output out_item_t       out_data
);

  logic [PX_W-1:0]  ram_rdata;
  logic             take;
  logic             room;

  // Read in flight: metadata is held in a register alongside the RAM read data.
  logic             rd_v_r, rd_v_nxt;
  cmd_t             meta_r;

  out_item_t        oq_r [OQ_DEPTH];
  logic [OQ_AW-1:0] oq_wr_r, oq_wr_nxt;
  logic [OQ_AW-1:0] oq_rd_r, oq_rd_nxt;
  logic [OQ_CW-1:0] oq_cnt_r, oq_cnt_nxt;
  logic             oq_push;
  logic             oq_pop;
  out_item_t        oq_in;

  // A read is issued only when its result has a guaranteed slot.
  assign room   = ((OQ_CW + 1)'(oq_cnt_r) + (OQ_CW + 1)'(rd_v_r)) <
                  (OQ_CW + 1)'(OQ_DEPTH);
  assign take   = !cq_status.empty && (!cq_head.is_read || room);
  assign cq_pop = take;

  rsf_ram #(
    .WIDTH (PX_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .en    (take),
    .we    (!cq_head.is_read),
    .addr  (cq_head.addr),
    .wdata (cq_head.wdata),
    .rdata (ram_rdata)
  );

  assign rd_v_nxt = take && cq_head.is_read;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r <= 1'b0;
    end else begin
      rd_v_r <= rd_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_v_nxt) begin
      meta_r <= cq_head;
    end
  end

  // Result beat assembled from RAM data and the saved position.
  always_comb begin
    oq_in.out_pixel  = ram_rdata;
    oq_in.native_row = meta_r.row;
    oq_in.native_col = meta_r.col;
    oq_in.chunk_last = meta_r.chunk_last;
    oq_in.frame_last = meta_r.frame_last;
  end

  assign oq_push   = rd_v_r;
  assign out_empty = (oq_cnt_r == '0);
  assign oq_pop    = out_pop && !out_empty;
  assign out_data  = oq_r[oq_rd_r];

  // Result queue pointers and fill count.
  always_comb begin
    oq_wr_nxt  = oq_wr_r;
    oq_rd_nxt  = oq_rd_r;
    oq_cnt_nxt = oq_cnt_r;
    if (oq_push) begin
      oq_wr_nxt = (oq_wr_r == OQ_AW'(OQ_DEPTH - 1)) ? '0 : oq_wr_r + OQ_AW'(1);
    end
    if (oq_pop) begin
      oq_rd_nxt = (oq_rd_r == OQ_AW'(OQ_DEPTH - 1)) ? '0 : oq_rd_r + OQ_AW'(1);
    end
    if (oq_push && !oq_pop) begin
      oq_cnt_nxt = oq_cnt_r + OQ_CW'(1);
    end else if (oq_pop && !oq_push) begin
      oq_cnt_nxt = oq_cnt_r - OQ_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_r  <= '0;
      oq_rd_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      oq_wr_r  <= oq_wr_nxt;
      oq_rd_r  <= oq_rd_nxt;
      oq_cnt_r <= oq_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (oq_push) begin
      oq_r[oq_wr_r] <= oq_in;
    end
  end

endmodule

`default_nettype wire

>>> rtl/rotating_shadow_framebuffer.sv
// Top level of the rotating shadow framebuffer: front end, command queue
// and back end with the shadow store. Uses rsf_pkg and the rsf_* modules.
//
//   Channel  | Ports                         | Beat accepted when
//   ---------+-------------------------------+----------------------------
//   input    | in_push, in_full, in_data     | in_push && !in_full
//   result   | out_empty, out_pop, out_data  | out_pop && !out_empty
//
// One beat is taken per cycle while the command queue has room; a read result
// passes through the command queue, the registered read of the single store
// port and the result queue before it shows on the result ports.
// Reset clears the queues and the raster counter; the store is not cleared.
// in_full rises when the command queue holds four commands; a read waits at
// the head of that queue while the result queue has no free slot, and every
// command behind it waits with it.
`timescale 1ns / 1ps
`default_nettype none

module rotating_shadow_framebuffer import rsf_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_push,
  output logic          in_full,
  input  wire in_item_t in_data,
  output logic          out_empty,
  input  wire logic     out_pop,
  output out_item_t     out_data
);

  cq_status_t cq_status;
  logic       cq_push;
  cmd_t       cq_cmd;
  logic       cq_pop;
  cmd_t       cq_head;

  assign in_full = cq_status.full;

  rsf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_data   (in_data),
    .cq_status (cq_status),
    .cq_push   (cq_push),
    .cq_cmd    (cq_cmd)
  );

  rsf_cmdq u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (cq_push),
    .push_cmd (cq_cmd),
    .pop      (cq_pop),
    .status   (cq_status),
    .head     (cq_head)
  );

  rsf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cq_status (cq_status),
    .cq_head   (cq_head),
    .cq_pop    (cq_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

>>> rtl/rsf_checker.sv
// Port-level checker for the rotating shadow framebuffer, bound to the top.
// Uses rsf_pkg for the geometry and beat types.
`timescale 1ns / 1ps
`default_nettype none

module rsf_checker import rsf_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_full,
  input wire logic      out_empty,
  input wire logic      out_pop,
  input wire out_item_t out_data
);

  // Reset leaves no result waiting.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  // Reset leaves room for input beats.
  a_reset_room: assert property (@(posedge clk) !rst_n |=> !in_full)
    else $error("input side full after reset");

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_data)))
    else $error("result beat changed while stalled");

  // The end of the frame also closes a chunk, on the last native row.
  a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.frame_last) |->
      (out_data.chunk_last && out_data.native_row == X_W'(UI_WIDTH - 1)))
    else $error("frame end flag on a wrong position");

  // A chunk ends only at the last column of a row.
  a_chunk_end: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.chunk_last) |->
      (out_data.native_col == Y_W'(UI_HEIGHT - 1)))
    else $error("chunk end flag inside a row");

endmodule

bind rotating_shadow_framebuffer rsf_checker u_rsf_checker (.*);

`default_nettype wire
